/* src/tlcu_pkg.sv */
package tlcu_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SIZE_W = 7;
    localparam int RULE_W = 18;
    localparam int CNT_W  = 4;
    localparam int POS_W  = 5;

    localparam logic [RULE_W-1:0] RULE_RESET    = 18'h01808;
    localparam logic [SIZE_W-1:0] SIZE_RESET    = 7'd64;
    localparam logic [POS_W-1:0]  SURVIVE_SHIFT = 5'd9;
    localparam logic [7:0]        FULL_LEVEL    = 8'd255;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_RULE = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_COLS = 2'd2;

    typedef logic [MAX_COLS-1:0] row_word_t;

endpackage

/* src/tlcu_ram.sv */
module tlcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/toroidal_life_rule_cell_update.sv */
// Life-like cell update on a toroidal grid of one-bit cells.
// Input channel (in_valid/in_stall) carries a load or a query transaction.
// A load sets the addressed cell alive when red, green and blue are all 255,
// and clears it otherwise; it produces no result. A query returns the next
// state of the cell from the rule register together with a bad_coord flag.
// Output channel (out_valid/out_stall) carries one result per query.
// The grid is held as one row word per memory entry. A load reads the row
// and then writes it back. A query reads the up, center and down rows in
// turn through the single read port, then applies the rule and registers
// the result; the next transaction is accepted only once that result has
// moved to the output register. A query outside the grid registers its
// result at acceptance and reads no rows. The next transaction is accepted
// while a result still waits in the output register; a finished query waits
// as long as the receiver stalls and the old result has not been taken.
// Reset restores the rule and grid size registers and marks every row as
// cleared through a per-row valid bit; no clearing pass is needed.
// The user must write the APB port only while the block is idle; the block itself does not enforce this.
module toroidal_life_rule_cell_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlcu_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [5:0]                    cell_row,
    input  logic [5:0]                    cell_col,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          next_alive,
    output logic                          bad_coord
);

    import tlcu_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOAD_WR = 3'd1;
    localparam logic [2:0] S_Q1      = 3'd2;
    localparam logic [2:0] S_Q2      = 3'd3;
    localparam logic [2:0] S_Q3      = 3'd4;
    localparam logic [2:0] S_OUT     = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [RULE_W-1:0]   rule_reg, rule_next;
    logic [SIZE_W-1:0]   rows_reg, rows_next;
    logic [SIZE_W-1:0]   cols_reg, cols_next;
    logic [MAX_ROWS-1:0] rv_reg, rv_next;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;
    logic                next_alive_reg, next_alive_next;
    logic                bad_coord_reg, bad_coord_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ROW_W-1:0]    down_reg, down_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [COL_W-1:0]    left_reg, left_next;
    logic [COL_W-1:0]    right_reg, right_next;
    logic                alive_reg, alive_next;
    logic [CNT_W-1:0]    nb_reg, nb_next;
    logic                own_reg, own_next;
    logic                res_alive_reg, res_alive_next;
    logic                res_bad_reg, res_bad_next;

    logic [SIZE_W-1:0]   rows_eff, cols_eff;
    logic [ROW_W-1:0]    in_row, up_c, down_c;
    logic [COL_W-1:0]    in_col, left_c, right_c;
    logic                inside_c, alive_c, accept, slot_free;
    logic                cfg_wr;
    logic                ram_we, ram_re;
    logic [ROW_W-1:0]    ram_waddr, ram_raddr;
    row_word_t           ram_wdata, ram_rdata, row_word, load_word;
    logic [CNT_W-1:0]    count;
    logic [POS_W-1:0]    pos;

    tlcu_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign next_alive = next_alive_reg;
    assign bad_coord  = bad_coord_reg;
    assign slot_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_RULE: prdata = {{(32-RULE_W){1'b0}}, rule_reg};
            REG_ROWS: prdata = {{(32-SIZE_W){1'b0}}, rows_reg};
            REG_COLS: prdata = {{(32-SIZE_W){1'b0}}, cols_reg};
            default:  prdata = '0;
        endcase
    end

    always_comb
    begin
        rows_eff = rows_reg;
        if (rows_reg == '0)
        begin
            rows_eff = SIZE_W'(1);
        end
        else if (rows_reg > SIZE_W'(MAX_ROWS))
        begin
            rows_eff = SIZE_W'(MAX_ROWS);
        end
        cols_eff = cols_reg;
        if (cols_reg == '0)
        begin
            cols_eff = SIZE_W'(1);
        end
        else if (cols_reg > SIZE_W'(MAX_COLS))
        begin
            cols_eff = SIZE_W'(MAX_COLS);
        end
    end

    assign in_row   = ROW_W'(cell_row);
    assign in_col   = COL_W'(cell_col);
    assign inside_c = (SIZE_W'(cell_row) < rows_eff) && (SIZE_W'(cell_col) < cols_eff);
    assign alive_c  = (red == FULL_LEVEL) && (green == FULL_LEVEL) && (blue == FULL_LEVEL);
    assign up_c     = (in_row == '0) ? ROW_W'(rows_eff - SIZE_W'(1)) : in_row - ROW_W'(1);
    assign down_c   = ((SIZE_W'(cell_row) + SIZE_W'(1)) == rows_eff) ? '0 : in_row + ROW_W'(1);
    assign left_c   = (in_col == '0) ? COL_W'(cols_eff - SIZE_W'(1)) : in_col - COL_W'(1);
    assign right_c  = ((SIZE_W'(cell_col) + SIZE_W'(1)) == cols_eff) ? '0 : in_col + COL_W'(1);

    assign row_word = hit_reg ? ram_rdata : '0;

    always_comb
    begin
        load_word          = row_word;
        load_word[col_reg] = alive_reg;
    end

    assign count = nb_reg + CNT_W'(row_word[left_reg]) + CNT_W'(row_word[col_reg])
                 + CNT_W'(row_word[right_reg]);
    assign pos   = own_reg ? (SURVIVE_SHIFT + POS_W'(count)) : POS_W'(count);

    always_comb
    begin
        state_next      = state_reg;
        rule_next       = rule_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        rv_next         = rv_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg;
        next_alive_next = next_alive_reg;
        bad_coord_next  = bad_coord_reg;
        row_next        = row_reg;
        down_next       = down_reg;
        col_next        = col_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        alive_next      = alive_reg;
        nb_next         = nb_reg;
        own_next        = own_reg;
        res_alive_next  = res_alive_reg;
        res_bad_next    = res_bad_reg;
        ram_we          = 1'b0;
        ram_waddr       = row_reg;
        ram_wdata       = load_word;
        ram_re          = 1'b0;
        ram_raddr       = row_reg;

        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_RULE: rule_next = pwdata[RULE_W-1:0];
                REG_ROWS: rows_next = pwdata[SIZE_W-1:0];
                REG_COLS: cols_next = pwdata[SIZE_W-1:0];
                default:  rule_next = rule_reg;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    row_next   = in_row;
                    col_next   = in_col;
                    down_next  = down_c;
                    left_next  = left_c;
                    right_next = right_c;
                    alive_next = alive_c;
                    if (!inside_c)
                    begin
                        if (cmd == CMD_QUERY)
                        begin
                            res_alive_next = 1'b0;
                            res_bad_next   = 1'b1;
                            state_next     = S_OUT;
                        end
                    end
                    else if (cmd == CMD_LOAD)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = in_row;
                        state_next = S_LOAD_WR;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = up_c;
                        state_next = S_Q1;
                    end
                end
            end
            S_LOAD_WR:
            begin
                ram_we           = 1'b1;
                rv_next[row_reg] = 1'b1;
                state_next       = S_IDLE;
            end
            S_Q1:
            begin
                nb_next    = CNT_W'(row_word[left_reg]) + CNT_W'(row_word[col_reg])
                           + CNT_W'(row_word[right_reg]);
                ram_re     = 1'b1;
                ram_raddr  = row_reg;
                state_next = S_Q2;
            end
            S_Q2:
            begin
                nb_next    = nb_reg + CNT_W'(row_word[left_reg]) + CNT_W'(row_word[right_reg]);
                own_next   = row_word[col_reg];
                ram_re     = 1'b1;
                ram_raddr  = down_reg;
                state_next = S_Q3;
            end
            S_Q3:
            begin
                res_alive_next = rule_reg[pos];
                res_bad_next   = 1'b0;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    next_alive_next = res_alive_reg;
                    bad_coord_next  = res_bad_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_re)
        begin
            hit_next = rv_reg[ram_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rule_reg      <= RULE_RESET;
            rows_reg      <= SIZE_RESET;
            cols_reg      <= SIZE_RESET;
            rv_reg        <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rule_reg      <= rule_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            rv_reg        <= rv_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        next_alive_reg <= next_alive_next;
        bad_coord_reg  <= bad_coord_next;
        row_reg        <= row_next;
        down_reg       <= down_next;
        col_reg        <= col_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        alive_reg      <= alive_next;
        nb_reg         <= nb_next;
        own_reg        <= own_next;
        res_alive_reg  <= res_alive_next;
        res_bad_reg    <= res_bad_next;
    end

    a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("Result appeared without a finished query.");

    a_load_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_LOAD && inside_c) |=> ram_we)
        else $error("Accepted load did not write its row back.");

    a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> rv_reg[$past(ram_waddr)])
        else $error("Written row is not marked valid.");

    a_bad_is_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_coord_reg) |-> !next_alive_reg)
        else $error("Out-of-range query reported a live cell.");

    a_no_access_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("Row write and row read issued in the same cycle.");

endmodule

/* verif/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlcu_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       cmd;
        logic [5:0] row;
        logic [5:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cell_txn_t;

    typedef struct packed {
        logic next_alive;
        logic bad_coord;
    } cell_result_t;

    typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t   kind;
        cell_txn_t    txn;
        bit           fixed;
        cell_result_t want;
        logic [1:0]   reg_idx;
        logic [31:0]  value;
    } directed_step_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              cmd = CMD_LOAD;
    logic [5:0]        cell_row = '0;
    logic [5:0]        cell_col = '0;
    logic [7:0]        red = '0;
    logic [7:0]        green = '0;
    logic [7:0]        blue = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              next_alive;
    logic              bad_coord;

    bit                life_cells [MAX_ROWS][MAX_COLS];
    logic [RULE_W-1:0] birth_survive_rule = RULE_RESET;
    logic [SIZE_W-1:0] grid_rows_now = SIZE_RESET;
    logic [SIZE_W-1:0] grid_cols_now = SIZE_RESET;
    cell_result_t      expected_states[$];

    bit no_idle = 1'b0;
    int hold_requests = 0;
    int errors = 0;
    int loads_seen = 0;
    int queries_seen = 0;
    int outside_seen = 0;
    int alive_seen = 0;
    int settings_used = 0;
    int cycles_without_transfer = 0;

    toroidal_life_rule_cell_update u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .next_alive (next_alive),
        .bad_coord  (bad_coord)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic int grid_extent(input logic [SIZE_W-1:0] size_setting, input int limit);
        if (size_setting == '0)
            return 1;
        if (int'(size_setting) > limit)
            return limit;
        return int'(size_setting);
    endfunction

    // Updates the cell copy for a load; returns 1 with the next state for a query.
    function automatic bit predict_cell_update(input cell_txn_t t, output cell_result_t res);
        int nrows;
        int ncols;
        int r;
        int c;
        int up;
        int down;
        int left;
        int right;
        int live;
        int pos;
        nrows = grid_extent(grid_rows_now, MAX_ROWS);
        ncols = grid_extent(grid_cols_now, MAX_COLS);
        r = int'(t.row);
        c = int'(t.col);
        res = '0;
        if (t.cmd == CMD_LOAD)
        begin
            if (r < nrows && c < ncols)
                life_cells[r][c] = (t.red == FULL_LEVEL && t.green == FULL_LEVEL
                                    && t.blue == FULL_LEVEL);
            return 1'b0;
        end
        if (r >= nrows || c >= ncols)
        begin
            res.bad_coord = 1'b1;
            return 1'b1;
        end
        up = (r + nrows - 1) % nrows;
        down = (r + 1) % nrows;
        left = (c + ncols - 1) % ncols;
        right = (c + 1) % ncols;
        live = int'(life_cells[up][left]) + int'(life_cells[up][c])
             + int'(life_cells[up][right]) + int'(life_cells[r][left])
             + int'(life_cells[r][right]) + int'(life_cells[down][left])
             + int'(life_cells[down][c]) + int'(life_cells[down][right]);
        pos = life_cells[r][c] ? int'(SURVIVE_SHIFT) + live : live;
        res.next_alive = birth_survive_rule[pos];
        return 1'b1;
    endfunction

    function automatic directed_step_t load_step(input int r, input int c, input int lr,
                                                 input int lg, input int lb);
        directed_step_t s;
        s = '{STEP_ITEM, '0, 1'b0, '0, REG_RULE, '0};
        s.txn = '{CMD_LOAD, 6'(r), 6'(c), 8'(lr), 8'(lg), 8'(lb)};
        return s;
    endfunction

    function automatic directed_step_t query_step(input int r, input int c, input bit fixed,
                                                  input bit alive, input bit outside);
        directed_step_t s;
        s = '{STEP_ITEM, '0, fixed, '0, REG_RULE, '0};
        s.txn = '{CMD_QUERY, 6'(r), 6'(c), 8'd0, 8'd0, 8'd0};
        s.want = '{alive, outside};
        return s;
    endfunction

    function automatic directed_step_t write_step(input logic [1:0] idx,
                                                  input logic [31:0] value);
        directed_step_t s;
        s = '{STEP_WRITE, '0, 1'b0, '0, idx, value};
        return s;
    endfunction

    function automatic logic [31:0] pick_grid_size();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'd127;
            2: return 32'(MAX_ROWS);
            3: return 32'($urandom_range(127, 65));
            4, 5, 6: return 32'($urandom_range(4, 1));
            7: return 32'($urandom_range(16, 1));
            default: return 32'($urandom_range(64, 1));
        endcase
    endfunction

    task automatic offer_cell_txn(input cell_txn_t t, input bit fixed,
                                  input cell_result_t fixed_res);
        cell_result_t res;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 24)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        cmd <= t.cmd;
        cell_row <= t.row;
        cell_col <= t.col;
        red <= t.red;
        green <= t.green;
        blue <= t.blue;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        if (predict_cell_update(t, res))
        begin
            queries_seen++;
            if (res.bad_coord)
                outside_seen++;
            if (res.next_alive)
                alive_seen++;
            expected_states.push_back(fixed ? fixed_res : res);
        end
        else
            loads_seen++;
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (expected_states.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        rdata = prdata;
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] stored;
        wait_until_idle();
        apb_cycle(1'b1, idx, value, readback);
        case (idx)
            REG_RULE: birth_survive_rule = value[RULE_W-1:0];
            REG_ROWS: grid_rows_now = value[SIZE_W-1:0];
            REG_COLS: grid_cols_now = value[SIZE_W-1:0];
            default: ;
        endcase
        if (idx != REG_UNUSED)
        begin
            stored = (idx == REG_RULE) ? 32'(birth_survive_rule)
                   : (idx == REG_ROWS) ? 32'(grid_rows_now) : 32'(grid_cols_now);
            apb_cycle(1'b0, idx, 32'd0, readback);
            if (readback !== stored)
                flag_error($sformatf("Register %0d read back: expected 0x%0h, got 0x%0h",
                                     idx, stored, readback));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        cell_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_states.size() == 0)
                flag_error($sformatf("Unexpected result: next_alive=%0b bad_coord=%0b",
                                     next_alive, bad_coord));
            else
            begin
                want = expected_states.pop_front();
                if (next_alive !== want.next_alive || bad_coord !== want.bad_coord)
                    flag_error($sformatf({"Result mismatch: expected next_alive=%0b ",
                                          "bad_coord=%0b, got next_alive=%0b bad_coord=%0b"},
                                         want.next_alive, want.bad_coord,
                                         next_alive, bad_coord));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            cycles_without_transfer = 0;
        else
            cycles_without_transfer++;
        if (cycles_without_transfer >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin : result_receiver
        int holds_done;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done < hold_requests)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 24);
        end
    end

    initial
    begin : stimulus
        directed_step_t directed_steps[$];
        cell_txn_t      t;
        int             nrows;
        int             ncols;
        int             focus_r;
        int             focus_c;
        logic [31:0]    rule_pick;

        directed_steps.push_back(query_step(0, 0, 1'b1, 1'b0, 1'b0));
        directed_steps.push_back(query_step(63, 63, 1'b1, 1'b0, 1'b0));
        directed_steps.push_back(load_step(0, 0, 255, 255, 255));
        directed_steps.push_back(load_step(0, 1, 255, 255, 255));
        directed_steps.push_back(load_step(63, 63, 255, 255, 255));
        directed_steps.push_back(query_step(0, 0, 1'b0, 1'b0, 1'b0));
        directed_steps.push_back(query_step(63, 0, 1'b0, 1'b0, 1'b0));
        directed_steps.push_back(query_step(63, 63, 1'b0, 1'b0, 1'b0));
        directed_steps.push_back(load_step(0, 1, 254, 255, 255));
        directed_steps.push_back(load_step(63, 63, 255, 254, 255));
        directed_steps.push_back(load_step(0, 0, 255, 255, 254));
        directed_steps.push_back(load_step(63, 0, 0, 0, 0));
        directed_steps.push_back(query_step(0, 1, 1'b0, 1'b0, 1'b0));
        directed_steps.push_back(write_step(REG_ROWS, 32'd5));
        directed_steps.push_back(write_step(REG_COLS, 32'd0));
        directed_steps.push_back(query_step(5, 0, 1'b1, 1'b0, 1'b1));
        directed_steps.push_back(query_step(0, 1, 1'b1, 1'b0, 1'b1));
        directed_steps.push_back(load_step(7, 0, 255, 255, 255));
        directed_steps.push_back(load_step(3, 0, 255, 255, 255));
        directed_steps.push_back(query_step(4, 0, 1'b0, 1'b0, 1'b0));
        directed_steps.push_back(write_step(REG_RULE, 32'h0003_FFFF));
        directed_steps.push_back(write_step(REG_ROWS, 32'd127));
        directed_steps.push_back(write_step(REG_COLS, 32'd65));
        directed_steps.push_back(write_step(REG_UNUSED, 32'h0001_5A5A));
        directed_steps.push_back(query_step(7, 0, 1'b0, 1'b0, 1'b0));
        directed_steps.push_back(write_step(REG_RULE, 32'd0));
        directed_steps.push_back(query_step(0, 0, 1'b1, 1'b0, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_WRITE)
                set_register(directed_steps[i].reg_idx, directed_steps[i].value);
            else
                offer_cell_txn(directed_steps[i].txn, directed_steps[i].fixed,
                               directed_steps[i].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(5))
                0: rule_pick = 32'(RULE_RESET);
                1: rule_pick = 32'd0;
                2: rule_pick = 32'h0003_FFFF;
                default: rule_pick = $urandom_range(262143);
            endcase
            set_register(REG_RULE, rule_pick);
            set_register(REG_ROWS, pick_grid_size());
            set_register(REG_COLS, pick_grid_size());
            settings_used++;
            no_idle = (ph == 4);
            if (ph == 8)
                hold_requests++;
            nrows = grid_extent(grid_rows_now, MAX_ROWS);
            ncols = grid_extent(grid_cols_now, MAX_COLS);
            focus_r = $urandom_range(nrows - 1);
            focus_c = $urandom_range(ncols - 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                t.cmd = ($urandom_range(1) == 1) ? CMD_QUERY : CMD_LOAD;
                // Most cells land in a small window so that neighborhoods fill up.
                if ($urandom_range(99) < 20)
                begin
                    t.row = 6'($urandom_range(63));
                    t.col = 6'($urandom_range(63));
                end
                else
                begin
                    t.row = 6'((focus_r + $urandom_range(4)) % nrows);
                    t.col = 6'((focus_c + $urandom_range(4)) % ncols);
                end
                t.red = 8'($urandom_range(255));
                t.green = 8'($urandom_range(255));
                t.blue = 8'($urandom_range(255));
                case ($urandom_range(9))
                    0, 1, 2, 3, 4:
                    begin
                        t.red = FULL_LEVEL;
                        t.green = FULL_LEVEL;
                        t.blue = FULL_LEVEL;
                    end
                    5, 6:
                    begin
                        t.red = 8'd0;
                        t.green = 8'd0;
                        t.blue = 8'd0;
                    end
                    7:
                    begin
                        t.red = FULL_LEVEL;
                        t.green = 8'($urandom_range(254));
                        t.blue = FULL_LEVEL;
                    end
                    default: ;
                endcase
                offer_cell_txn(t, 1'b0, '0);
            end
        end

        wait_until_idle();
        $display("Covered %0d loads and %0d queries (%0d outside the grid, %0d live next).",
                 loads_seen, queries_seen, outside_seen, alive_seen);
        $display("Used %0d random rule and grid settings; %0d errors found.",
                 settings_used, errors);
        if (errors == 0 && expected_states.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
src/tlcu_pkg.sv
src/tlcu_ram.sv
src/toroidal_life_rule_cell_update.sv
verif/testbench.sv
